### design/hmm_viterbi_decoder_macros.svh
// Assertion macros for the HMM Viterbi decoder checker
`ifndef HMM_VITERBI_DECODER_MACROS_SVH
`define HMM_VITERBI_DECODER_MACROS_SVH
// implication checked on every edge outside reset
`define HVD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define HVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### design/hvd_pkg.sv
// Shared types and constants for the HMM Viterbi decoder
package hvd_pkg;
	localparam int CostW = 16;
	localparam int MetricW = 24;
	localparam int MaxStates = 8;
	localparam int MaxSymbols = 16;
	localparam logic [CostW-1:0] CostImpossible = 16'hFFFF;
	localparam logic [MetricW-1:0] MetricSat = 24'hFFFFFF;

	typedef enum logic [1:0] {
		CMD_TRANS = 2'd0,
		CMD_EMIT  = 2'd1,
		CMD_INIT  = 2'd2,
		CMD_OBS   = 2'd3
	} cmd_t;

	localparam logic [0:0] CfgNumStates = 1'b0;
	localparam logic [0:0] CfgNumSymbols = 1'b1;

	// saturating metric + two table costs
	function automatic logic [MetricW-1:0] sat_add(input logic [MetricW-1:0] m,
		input logic [CostW-1:0] c1, input logic [CostW-1:0] c2);
		logic [MetricW+1:0] s;
		s = {2'b00, m} + {{(MetricW-CostW+2){1'b0}}, c1} + {{(MetricW-CostW+2){1'b0}}, c2};
		if (c1 == CostImpossible || c2 == CostImpossible || m == MetricSat)
			return MetricSat;
		if (s > {2'b00, MetricSat})
			return MetricSat;
		return s[MetricW-1:0];
	endfunction
endpackage

### design/hvd_acs.sv
// Shared add-compare-select unit: one candidate per cycle while step is high
module hvd_acs (
	input  logic clk,
	input  logic start,
	input  logic step,
	input  logic [hvd_pkg::MetricW-1:0] metric,
	input  logic [hvd_pkg::CostW-1:0] cost_a,
	input  logic [hvd_pkg::CostW-1:0] cost_b,
	input  logic [4:0] src,
	output logic [hvd_pkg::MetricW-1:0] best,
	output logic [4:0] best_src
);
	import hvd_pkg::*;
	logic [MetricW-1:0] cand;
	logic [MetricW-1:0] best_q;
	logic [4:0] best_src_q;

	assign cand = sat_add(metric, cost_a, cost_b);

	always_ff @(posedge clk) begin
		if (step) begin
			if (start || cand < best_q) begin
				best_q <= cand;
				best_src_q <= src;
			end
		end
	end

	assign best = best_q;
	assign best_src = best_src_q;
endmodule

### design/hmm_viterbi_decoder.sv
// HMM Viterbi decoder top level: tables, sequencer and traceback
//
// Input channel (valid/stall): command, first_index, second_index, cost and
// last_observation. A table write leaves in_stall low, so writes can follow
// back to back. An observation runs the shared add-compare-select unit once
// per (destination, source) pair, or once per destination for the first
// observation of a sequence, then stores each destination's result in a
// drain state. On the last observation, an argmax over ns states (one per
// cycle) is followed by a traceback of len-1 steps, each through ST_TB and
// ST_TB_WAIT with one back-pointer memory read, and then len result items go
// out in forward order, one per cycle while the output is not stalled.
// in_stall stays high throughout. Output channel (valid/stall): state_index,
// last_state. A stalled result holds. Reset clears the sequence length and
// sequencer; tables are undefined until written. Configuration (num_states,
// num_symbols) is written through cfg_valid/cfg_ready, index and data; the
// user must do so only while idle, which the block does not enforce.
module hmm_viterbi_decoder #(
	parameter int MAX_LEN = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] command,
	input  logic [2:0] first_index,
	input  logic [3:0] second_index,
	input  logic [15:0] cost,
	input  logic last_observation,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] state_index,
	output logic last_state,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [4:0] cfg_data
);
	import hvd_pkg::*;
	localparam int SW = $clog2(MaxStates);
	localparam int YW = $clog2(MaxSymbols);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int TW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_ACS, ST_ACS_WB, ST_COPY, ST_ARG, ST_ARG_WB,
		ST_TB, ST_TB_WAIT, ST_OUT
	} state_t;

	state_t state_q;
	logic [3:0] ns_reg_q;
	logic [4:0] nsym_reg_q;
	logic [LW-1:0] len_q;
	logic [SW-1:0] dst_q, src_q;
	logic [YW-1:0] sym_q;
	logic last_q;
	logic [TW-1:0] t_q;
	logic [SW-1:0] cur_q;
	logic [LW-1:0] oidx_q;
	logic out_valid_q;
	logic [2:0] state_index_q;
	logic last_state_q;

	logic [CostW-1:0] trans_mem [MaxStates*MaxStates];
	logic [CostW-1:0] emit_mem [MaxStates*MaxSymbols];
	logic [CostW-1:0] init_cost_q [MaxStates];
	logic [MetricW-1:0] pm_q [MaxStates];
	logic [MetricW-1:0] nx_q [MaxStates];
	logic [SW-1:0] bp_mem [MAX_LEN*MaxStates];
	logic [SW-1:0] path_q [MAX_LEN];

	logic [CostW-1:0] trans_rd_q, emit_rd_q;
	logic [SW-1:0] bp_rd_q;

	// clamped counts
	logic [5:0] ns, nsym;
	always_comb begin
		ns = (ns_reg_q == 4'd0) ? 6'd1 : {2'b00, ns_reg_q};
		if (ns > 6'(MaxStates)) ns = 6'(MaxStates);
		nsym = (nsym_reg_q == 5'd0) ? 6'd1 : {1'b0, nsym_reg_q};
		if (nsym > 6'(MaxSymbols)) nsym = 6'(MaxSymbols);
	end

	logic acc;
	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// sequencing: in ACS, src_q/dst_q address reads, pipelined through the s1 registers
	logic rd_v_s1, rd_first_s1;
	logic [SW-1:0] rd_src_s1, rd_dst_s1;
	logic acs_step;
	logic [MetricW-1:0] acs_metric;
	logic [CostW-1:0] acs_a;
	logic [4:0] acs_src;
	logic [MetricW-1:0] acs_best;
	logic [4:0] acs_best_src;
	logic init_mode_s1;

	always_comb begin
		acs_step = rd_v_s1;
		acs_metric = init_mode_s1 ? '0 : pm_q[rd_src_s1];
		acs_a = init_mode_s1 ? init_cost_q[rd_dst_s1] : trans_rd_q;
		acs_src = 5'(rd_src_s1);
	end

	hvd_acs u_acs (
		.clk(clk), .start(rd_first_s1), .step(acs_step), .metric(acs_metric),
		.cost_a(acs_a), .cost_b(emit_rd_q), .src(acs_src),
		.best(acs_best), .best_src(acs_best_src)
	);

	// memory writes and reads
	always_ff @(posedge clk) begin
		if (acc && cmd_t'(command) == CMD_TRANS && second_index < 4'(MaxStates))
			trans_mem[{first_index, second_index[SW-1:0]}] <= cost;
		if (acc && cmd_t'(command) == CMD_EMIT)
			emit_mem[{first_index, second_index}] <= cost;
		if (acc && cmd_t'(command) == CMD_INIT)
			init_cost_q[first_index] <= cost;
		trans_rd_q <= trans_mem[{src_q, dst_q}];
		emit_rd_q <= emit_mem[{dst_q, sym_q}];
		bp_rd_q <= bp_mem[{t_q, cur_q}];
		if (state_q == ST_ACS_WB && rd_v_s1 == 1'b0)
			bp_mem[{len_q[TW-1:0], dst_q}] <= acs_best_src[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ns_reg_q <= 4'd8;
			nsym_reg_q <= 5'd16;
			len_q <= '0;
			out_valid_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			rd_first_s1 <= 1'b0;
			init_mode_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CfgNumStates) ns_reg_q <= cfg_data[3:0];
				else nsym_reg_q <= cfg_data;
			end
			rd_v_s1 <= 1'b0;
			rd_first_s1 <= (src_q == '0);
			rd_src_s1 <= src_q;
			rd_dst_s1 <= dst_q;
			case (state_q)
				ST_IDLE: begin
					if (acc && cmd_t'(command) == CMD_OBS) begin
						sym_q <= YW'(second_index);
						last_q <= last_observation;
						dst_q <= '0;
						src_q <= '0;
						if (6'(second_index) < nsym && len_q < LW'(MAX_LEN)) begin
							init_mode_s1 <= (len_q == '0);
							state_q <= (len_q == '0) ? ST_INIT : ST_ACS;
						end else if (last_observation) begin
							dst_q <= '0;
							state_q <= (len_q == '0) ? ST_IDLE : ST_ARG;
						end
					end
				end
				ST_INIT: begin
					// one candidate per destination, src fixed at 0
					rd_v_s1 <= 1'b1;
					state_q <= ST_ACS_WB;
				end
				ST_ACS: begin
					rd_v_s1 <= 1'b1;
					if (6'(src_q) + 6'd1 == ns) begin
						src_q <= '0;
						state_q <= ST_ACS_WB;
					end else
						src_q <= src_q + 1'b1;
				end
				ST_ACS_WB: begin
					// wait for last candidate to land, then store
					if (!rd_v_s1) begin
						nx_q[dst_q] <= acs_best;
						if (6'(dst_q) + 6'd1 == ns) begin
							state_q <= ST_COPY;
						end else begin
							dst_q <= dst_q + 1'b1;
							state_q <= init_mode_s1 ? ST_INIT : ST_ACS;
						end
					end
				end
				ST_COPY: begin
					for (int i = 0; i < MaxStates; i++)
						if (i < int'(ns)) pm_q[i] <= nx_q[i];
					len_q <= len_q + 1'b1;
					init_mode_s1 <= 1'b0;
					dst_q <= '0;
					state_q <= last_q ? ST_ARG : ST_IDLE;
				end
				ST_ARG: begin
					// argmax over states, one compare per cycle
					if (dst_q == '0 || pm_q[dst_q] < nx_q[0]) begin
						nx_q[0] <= pm_q[dst_q];
						cur_q <= dst_q;
					end
					if (6'(dst_q) + 6'd1 == ns) state_q <= ST_ARG_WB;
					else dst_q <= dst_q + 1'b1;
				end
				ST_ARG_WB: begin
					t_q <= TW'(len_q - 1'b1);
					path_q[TW'(len_q - 1'b1)] <= cur_q;
					state_q <= (len_q == LW'(1)) ? ST_OUT : ST_TB;
					oidx_q <= '0;
				end
				ST_TB: state_q <= ST_TB_WAIT;
				ST_TB_WAIT: begin
					path_q[t_q - 1'b1] <= bp_rd_q;
					cur_q <= bp_rd_q;
					t_q <= t_q - 1'b1;
					state_q <= (t_q == TW'(1)) ? ST_OUT : ST_TB;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						if (oidx_q == len_q) begin
							out_valid_q <= 1'b0;
							len_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							out_valid_q <= 1'b1;
							state_index_q <= 3'(path_q[oidx_q[TW-1:0]]);
							last_state_q <= (oidx_q + 1'b1 == len_q);
							oidx_q <= oidx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign state_index = state_index_q;
	assign last_state = last_state_q;
endmodule

### design/hvd_checker.sv
// Port-level checker for the HMM Viterbi decoder, bound to the top level
`include "hmm_viterbi_decoder_macros.svh"
module hvd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] state_index,
	input logic last_state
);
	`HVD_ASSERT_IMP(a_no_accept_during_output, clk, arst_n, out_valid, in_stall, "input taken while results pending")
	`HVD_ASSERT_NEXT(a_hold_stalled, clk, arst_n, out_valid && out_stall, out_valid && $stable(state_index) && $stable(last_state), "stalled result changed")
	`HVD_ASSERT_NEXT(a_busy_after_last, clk, arst_n, out_valid && !out_stall && !last_state, in_stall, "block idle mid-sequence")
endmodule

bind hmm_viterbi_decoder hvd_checker u_hvd_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .state_index(state_index),
	.last_state(last_state)
);

### sim/tb_hmm_viterbi_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for the HMM Viterbi decoder: table loads, directed and random sequences
module tb_hmm_viterbi_decoder;
	import hvd_pkg::*;

	localparam int NumStates = 8;
	localparam int NumSymbols = 16;
	localparam int SeqCap = 64;
	localparam int DrainCycles = 120;

	typedef struct packed {
		logic [2:0] st;
		logic lst;
	} decoded_t;

	typedef struct {
		cmd_t cmd;
		logic [2:0] a;
		logic [3:0] b;
		logic [15:0] k;
		logic lst;
		int n_exp;          // -1: predictor only
		logic [2:0] st_exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = CMD_TRANS;
	logic [2:0] first_index = '0;
	logic [3:0] second_index = '0;
	logic [15:0] cost = '0;
	logic last_observation = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] state_index;
	logic last_state;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CfgNumStates;
	logic [4:0] cfg_data = '0;

	// typed expectation riding along with the item on the bus
	int typed_n = -1;
	logic [2:0] typed_st = '0;

	hmm_viterbi_decoder dut (.*);

	always #5 clk = ~clk;

	// decoder shadow state
	logic [15:0] trans_cost [NumStates*NumStates];
	logic [15:0] emit_cost [NumStates*NumSymbols];
	logic [15:0] init_cost [NumStates];
	logic [23:0] path_metric [NumStates];
	logic [2:0] back_ptr [SeqCap*NumStates];
	int seq_len = 0;
	logic [3:0] states_reg = 4'd8;
	logic [4:0] symbols_reg = 5'd16;

	decoded_t pending_q[$];
	int errors = 0;
	int burst_left = 0;

	function automatic int clamp_cnt(int v, int top);
		if (v == 0) return 1;
		return v > top ? top : v;
	endfunction

	function automatic logic [23:0] path_add(logic [23:0] m, logic [15:0] c1, logic [15:0] c2);
		logic [25:0] s;
		if (c1 == CostImpossible || c2 == CostImpossible || m == MetricSat) return MetricSat;
		s = {2'b0, m} + c1 + c2;
		return s > {2'b0, MetricSat} ? MetricSat : s[23:0];
	endfunction

	function automatic void note_error(string msg);
		errors++;
		if (errors <= 10) $display("mismatch: %s", msg);
	endfunction

	function automatic void extend_paths(int sym, int ns);
		logic [23:0] nxt [NumStates];
		logic [23:0] best, c;
		int bsrc;
		if (seq_len == 0) begin
			for (int d = 0; d < ns; d++)
				path_metric[d] = path_add('0, init_cost[d], emit_cost[d*NumSymbols+sym]);
			seq_len = 1;
			return;
		end
		for (int d = 0; d < ns; d++) begin
			best = '0;
			bsrc = 0;
			for (int s = 0; s < ns; s++) begin
				c = path_add(path_metric[s], trans_cost[s*NumStates+d],
					emit_cost[d*NumSymbols+sym]);
				if (s == 0 || c < best) begin
					best = c;
					bsrc = s;
				end
			end
			nxt[d] = best;
			back_ptr[seq_len*NumStates+d] = bsrc[2:0];
		end
		for (int d = 0; d < ns; d++) path_metric[d] = nxt[d];
		seq_len++;
	endfunction

	// returns number of decoded states queued; first one in st0
	function automatic int trace_back(int ns, output logic [2:0] st0);
		logic [2:0] path [SeqCap];
		logic [23:0] best;
		int st, n;
		decoded_t d;
		st0 = '0;
		n = seq_len;
		if (n == 0) return 0;
		best = '0;
		st = 0;
		for (int s = 0; s < ns; s++)
			if (s == 0 || path_metric[s] < best) begin
				best = path_metric[s];
				st = s;
			end
		path[n-1] = st[2:0];
		for (int t = n - 1; t > 0; t--) begin
			st = int'(back_ptr[t*NumStates+st]);
			path[t-1] = st[2:0];
		end
		for (int t = 0; t < n; t++) begin
			d.st = path[t];
			d.lst = (t == n - 1);
			pending_q.insert(pending_q.size(), d);
		end
		st0 = path[0];
		seq_len = 0;
		return n;
	endfunction

	function automatic void predict_item(logic [1:0] c, logic [2:0] a, logic [3:0] b,
		logic [15:0] k, logic lst, int t_n, logic [2:0] t_st);
		int ns, nsym, n;
		logic [2:0] st0;
		ns = clamp_cnt(int'(states_reg), NumStates);
		nsym = clamp_cnt(int'(symbols_reg), NumSymbols);
		n = 0;
		st0 = '0;
		case (cmd_t'(c))
			CMD_TRANS: if (b < NumStates) trans_cost[a*NumStates+b] = k;
			CMD_EMIT: emit_cost[a*NumSymbols+b] = k;
			CMD_INIT: init_cost[a] = k;
			CMD_OBS: begin
				if (b < nsym && seq_len < SeqCap) extend_paths(int'(b), ns);
				if (lst) n = trace_back(ns, st0);
			end
			default: ;
		endcase
		if (t_n >= 0 && (n != t_n || (n > 0 && st0 !== t_st)))
			note_error($sformatf("typed row: exp %0d results first %0d, model %0d first %0d",
				t_n, t_st, n, st0));
	endfunction

	// input, config and output monitor
	always @(posedge clk) begin
		decoded_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_item(command, first_index, second_index, cost, last_observation,
					typed_n, typed_st);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CfgNumStates) states_reg <= cfg_data[3:0];
				else symbols_reg <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					note_error($sformatf("unexpected state %0d last %0d", state_index, last_state));
				end else begin
					e = pending_q.pop_front();
					if (state_index !== e.st || last_state !== e.lst)
						note_error($sformatf("state exp %0d got %0d, last exp %0d got %0d",
							e.st, state_index, e.lst, last_state));
				end
			end
		end
	end

	// receiver stalls: modes of none, light, heavy
	int stall_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send(logic [1:0] c, logic [2:0] a, logic [3:0] b, logic [15:0] k,
		logic lst, int t_n = -1, logic [2:0] t_st = '0);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= c;
		first_index <= a;
		second_index <= b;
		cost <= k;
		last_observation <= lst;
		typed_n <= t_n;
		typed_st <= t_st;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	task automatic write_reg(logic idx, logic [4:0] val);
		in_valid <= 1'b0;
		burst_left = 0;
		wait (pending_q.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_cost();
		case ($urandom_range(0, 9))
			0: return CostImpossible;
			1: return 16'd0;
			2: return 16'hFFFE;
			3, 4: return 16'($urandom);
			default: return 16'($urandom_range(0, 3000));
		endcase
	endfunction

	task automatic load_tables();
		for (int s = 0; s < NumStates; s++) begin
			send(CMD_INIT, 3'(s), 4'($urandom), rand_cost(), 1'($urandom));
			for (int d = 0; d < NumStates; d++)
				send(CMD_TRANS, 3'(s), 4'(d), rand_cost(), 1'($urandom));
			for (int y = 0; y < NumSymbols; y++)
				send(CMD_EMIT, 3'(s), 4'(y), rand_cost(), 1'($urandom));
		end
	endtask

	// one sequence closed by its last observation; mostly valid symbols, some noise
	task automatic run_sequence(int len);
		int nsym;
		logic [3:0] sym;
		nsym = clamp_cnt(int'(symbols_reg), NumSymbols);
		for (int i = 0; i < len; i++) begin
			case ((i == len - 1) ? 19 : $urandom_range(0, 19))
				0: send(CMD_TRANS, 3'($urandom), 4'($urandom), rand_cost(), 1'($urandom));
				1: send(CMD_EMIT, 3'($urandom), 4'($urandom), rand_cost(), 1'($urandom));
				2: send(CMD_INIT, 3'($urandom), 4'($urandom), rand_cost(), 1'($urandom));
				default: begin
					sym = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, nsym - 1));
					send(CMD_OBS, 3'($urandom), sym, 16'($urandom), i == len - 1);
				end
			endcase
		end
	endtask

	stim_row_t directed[] = '{
		// single observation: only state 5 is possible at start
		'{CMD_INIT, 3'd0, 4'd0, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_INIT, 3'd1, 4'd0, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_INIT, 3'd2, 4'd0, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_INIT, 3'd3, 4'd0, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_INIT, 3'd4, 4'd0, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_INIT, 3'd5, 4'd0, 16'h0000, 1'b0, 0, 3'd0},
		'{CMD_INIT, 3'd6, 4'd0, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_INIT, 3'd7, 4'd0, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_EMIT, 3'd5, 4'd15, 16'h0000, 1'b0, 0, 3'd0},
		'{CMD_OBS, 3'd0, 4'd15, 16'h0000, 1'b1, 1, 3'd5},
		// another single observation, decoded directly
		'{CMD_OBS, 3'd7, 4'd0, 16'hFFFF, 1'b1, -1, 3'd0},
		// destination out of range: ignored
		'{CMD_TRANS, 3'd7, 4'd8, 16'h0000, 1'b0, 0, 3'd0},
		'{CMD_TRANS, 3'd0, 4'd15, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_TRANS, 3'd5, 4'd7, 16'hFFFE, 1'b0, 0, 3'd0},
		'{CMD_TRANS, 3'd7, 4'd7, 16'h0000, 1'b0, 0, 3'd0},
		'{CMD_EMIT, 3'd7, 4'd0, 16'hFFFF, 1'b0, 0, 3'd0},
		'{CMD_OBS, 3'd3, 4'd15, 16'h1234, 1'b0, 0, 3'd0},
		'{CMD_OBS, 3'd0, 4'd0, 16'h0000, 1'b0, 0, 3'd0},
		'{CMD_OBS, 3'd7, 4'd15, 16'hFFFF, 1'b1, -1, 3'd0},
		'{CMD_OBS, 3'd0, 4'd8, 16'h0000, 1'b0, 0, 3'd0},
		'{CMD_OBS, 3'd1, 4'd3, 16'h00FF, 1'b1, -1, 3'd0}
	};

	initial begin
		int left;
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_tables();
		foreach (directed[i])
			send(directed[i].cmd, directed[i].a, directed[i].b, directed[i].k,
				directed[i].lst, directed[i].n_exp, directed[i].st_exp);

		// single state and single symbol, then an over-long sequence
		write_reg(CfgNumStates, 5'd1);
		write_reg(CfgNumSymbols, 5'd1);
		run_sequence(3);
		for (int i = 0; i < SeqCap + 6; i++)
			send(CMD_OBS, 3'($urandom), 4'd0, 16'($urandom), i == SeqCap + 5);
		send(CMD_OBS, 3'd0, 4'd9, 16'd0, 1'b1);

		// register value zero acts as one; upper extremes clamp
		write_reg(CfgNumStates, 5'd0);
		write_reg(CfgNumSymbols, 5'd0);
		run_sequence(4);
		write_reg(CfgNumStates, 5'd31);
		write_reg(CfgNumSymbols, 5'd31);
		run_sequence(6);
		write_reg(CfgNumStates, 5'd8);
		write_reg(CfgNumSymbols, 5'd16);
		run_sequence(12);

		left = 43;
		while (left > 0) begin
			if ($urandom_range(0, 4) == 0) begin
				write_reg(CfgNumStates, 5'($urandom_range(0, 31)));
				write_reg(CfgNumSymbols, 5'($urandom_range(0, 31)));
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			if (n > left) n = left;
			run_sequence(n);
			left -= n;
		end

		in_valid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
